### design/ryuv420_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the RGB to YUV 4:2:0 stream block.
// Used by ryuv420_csc, ryuv420_addr and rgb_to_yuv420_stream.
package ryuv420_pkg;

  localparam int PIX_W      = 8;   // one color component or one output byte
  localparam int DIM_W      = 13;  // frame size registers and config data
  localparam int CFG_IDX_W  = 2;
  localparam int AREA_W     = 2 * DIM_W;
  localparam int LUMA_W     = 24;
  localparam int CHROMA_W   = 25;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int RST_WIDTH      = 640;
  localparam int RST_HEIGHT     = 480;

  // BT.601 studio-swing integer coefficients
  localparam int C_Y_R  = 66;
  localparam int C_Y_G  = 129;
  localparam int C_Y_B  = 25;
  localparam int C_U_R  = 38;   // subtracted
  localparam int C_U_G  = 74;   // subtracted
  localparam int C_U_B  = 112;
  localparam int C_V_R  = 112;
  localparam int C_V_G  = 94;   // subtracted
  localparam int C_V_B  = 18;   // subtracted
  localparam int C_ROUND    = 128;
  localparam int C_Y_OFS    = 16;
  localparam int C_CHR_OFS  = 128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic step;     // pixel accepted this cycle
    logic restart;  // frame size written: clear counters
    logic reload;   // area is fresh: load chroma pointers
  } addr_ctrl_t;

  typedef struct packed {
    logic [LUMA_W-1:0]   luma_offset;
    logic                chroma_valid;
    logic                chroma_is_u;
    logic [CHROMA_W-1:0] chroma_offset;
    logic                frame_done;
  } addr_info_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int maxv);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if ((DIM_W+1)'(v) > (DIM_W+1)'(maxv)) begin
      res = DIM_W'(maxv);
    end
    return res;
  endfunction

endpackage

### design/ryuv420_csc.sv
`timescale 1ns / 1ps
// Integer BT.601 color space conversion of one pixel, Y, Cb and Cr in parallel.
// Depends on ryuv420_pkg for the coefficients.
module ryuv420_csc
  import ryuv420_pkg::*;
(
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] blue,
  output logic [PIX_W-1:0] luma,
  output logic [PIX_W-1:0] cb,
  output logic [PIX_W-1:0] cr
);

  logic [15:0] y_sum;
  logic [15:0] u_sum;
  logic [15:0] v_sum;

  // Bias of 128*256 keeps the chroma sums positive, so the shift is a floor plus 128.
  assign y_sum = 16'(red) * 16'(C_Y_R) + 16'(green) * 16'(C_Y_G)
               + 16'(blue) * 16'(C_Y_B) + 16'(C_ROUND);
  assign u_sum = 16'(blue) * 16'(C_U_B) + 16'(C_ROUND + (C_CHR_OFS << PIX_W))
               - 16'(red) * 16'(C_U_R) - 16'(green) * 16'(C_U_G);
  assign v_sum = 16'(red) * 16'(C_V_R) + 16'(C_ROUND + (C_CHR_OFS << PIX_W))
               - 16'(green) * 16'(C_V_G) - 16'(blue) * 16'(C_V_B);

  assign luma = y_sum[15:8] + PIX_W'(C_Y_OFS);
  assign cb   = u_sum[15:8];
  assign cr   = v_sum[15:8];

endmodule

### design/ryuv420_addr.sv
`timescale 1ns / 1ps
// Raster position counters and output buffer pointers for luma and interleaved chroma.
// Depends on ryuv420_pkg for the control and address structs.
module ryuv420_addr
  import ryuv420_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  addr_ctrl_t        ctrl,
  input  logic [DIM_W-1:0]  frame_width,
  input  logic [DIM_W-1:0]  frame_height,
  input  logic [AREA_W-1:0] area,
  output addr_info_t        info
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_r;
  logic [LUMA_W-1:0]   luma_r;
  logic [CHROMA_W-1:0] u_ptr_r;
  logic [CHROMA_W-1:0] v_ptr_r;

  logic                col_last;
  logic                row_last;
  logic                last;
  logic                chroma_on;
  logic                row_even;
  logic [CHROMA_W-1:0] area_lo;

  assign col_last  = ((DIM_W+1)'(col_r) + (DIM_W+1)'(1)) >= (DIM_W+1)'(frame_width);
  assign row_last  = ((DIM_W+1)'(row_r) + (DIM_W+1)'(1)) >= (DIM_W+1)'(frame_height);
  assign last      = col_last & row_last;
  assign chroma_on = ~col_r[0];
  assign row_even  = ~row_r[0];
  assign area_lo   = area[CHROMA_W-1:0];

  always_comb begin
    info.luma_offset   = luma_r;
    info.chroma_valid  = chroma_on;
    info.chroma_is_u   = chroma_on & row_even;
    info.chroma_offset = '0;
    if (chroma_on) begin
      info.chroma_offset = row_even ? u_ptr_r : v_ptr_r;
    end
    info.frame_done    = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      luma_r  <= '0;
      u_ptr_r <= '0;
      v_ptr_r <= '0;
    end else begin
      if (ctrl.restart) begin
        col_r  <= '0;
        row_r  <= '0;
        luma_r <= '0;
      end else if (ctrl.step) begin
        luma_r <= luma_r + LUMA_W'(1);
        if (chroma_on && row_even) begin
          u_ptr_r <= u_ptr_r + CHROMA_W'(2);
        end else if (chroma_on) begin
          v_ptr_r <= v_ptr_r + CHROMA_W'(2);
        end
        if (last) begin
          // wrap to frame start
          col_r   <= '0;
          row_r   <= '0;
          luma_r  <= '0;
          v_ptr_r <= area_lo;
          u_ptr_r <= area_lo + CHROMA_W'(1);
        end else if (col_last) begin
          col_r <= '0;
          row_r <= row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
      if (ctrl.reload) begin
        v_ptr_r <= area_lo;
        u_ptr_r <= area_lo + CHROMA_W'(1);
      end
    end
  end

endmodule

### design/rgb_to_yuv420_stream.sv
`timescale 1ns / 1ps
// RGB to YUV 4:2:0 pixel stream: top level with config registers and result register.
// Depends on ryuv420_pkg, ryuv420_csc and ryuv420_addr.
//
// Usage:
//   Pixels enter on the in_ channel in raster order, one per transaction (valid/stall).
//   Each pixel gives one transaction on the out_ channel: the Y byte with its luma
//   offset, and on even columns a chroma byte (U on even rows, V on odd rows) with its
//   offset in the interleaved chroma area that starts at width*height.
//   The last pixel of a frame carries frame_done and the frame byte count; the
//   counters then wrap to frame start.
//   The result of an accepted pixel is registered and presented in the next cycle.
//   Throughput is one pixel per cycle unless in_stall is high; a new pixel is taken while
//   the previous result is taken: the single result register refills in the same cycle.
//   When the receiver stalls with a result pending, in_stall rises in the same cycle.
//   Frame size is written on the cfg_ port (index 0 width, 1 height); the user must do
//   so only while idle, which the block does not enforce. A write restarts the frame and
//   in_stall is then high while the frame area is multiplied out and the chroma pointers
//   load. cfg_ready is always high. Reset: synchronous, active low; 640x480, output empty,
//   and the same area setup as after a config write before the first pixel is accepted.
module rgb_to_yuv420_stream
  import ryuv420_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  // pixel input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_blue_in,
  input  logic [PIX_W-1:0]     in_green_in,
  input  logic [PIX_W-1:0]     in_red_in,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_luma_value,
  output logic [LUMA_W-1:0]    out_luma_offset,
  output logic                 out_chroma_valid,
  output logic                 out_chroma_is_u,
  output logic [PIX_W-1:0]     out_chroma_value,
  output logic [CHROMA_W-1:0]  out_chroma_offset,
  output logic                 out_frame_done,
  output logic [CHROMA_W-1:0]  out_frame_bytes
);

  localparam logic [DIM_W-1:0] WIDTH_RST  =
    DIM_W'((RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_RST =
    DIM_W'((RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT);

  logic [DIM_W-1:0]    width_r;
  logic [DIM_W-1:0]    height_r;
  logic                area_pend_r;
  logic                ptr_pend_r;
  logic [AREA_W-1:0]   area_r;
  logic [AREA_W-1:0]   area_nxt;
  logic [CHROMA_W-1:0] fbytes_r;
  logic [CHROMA_W-1:0] fbytes_nxt;
  logic                out_valid_r;

  logic                cfg_we;
  logic                cfg_hit;
  logic                in_acc;
  addr_ctrl_t          actrl;
  addr_info_t          ainfo;

  logic [PIX_W-1:0]    y_val;
  logic [PIX_W-1:0]    cb_val;
  logic [PIX_W-1:0]    cr_val;

  logic [PIX_W-1:0]    luma_value_r;
  logic [LUMA_W-1:0]   luma_offset_r;
  logic                chroma_valid_r;
  logic                chroma_is_u_r;
  logic [PIX_W-1:0]    chroma_value_r;
  logic [PIX_W-1:0]    chroma_value_nxt;
  logic [CHROMA_W-1:0] chroma_offset_r;
  logic                frame_done_r;
  logic [CHROMA_W-1:0] frame_bytes_r;
  logic [CHROMA_W-1:0] frame_bytes_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign cfg_hit   = cfg_we && (cfg_index == REG_FRAME_WIDTH ||
                                cfg_index == REG_FRAME_HEIGHT);

  assign in_stall = area_pend_r | ptr_pend_r | (out_valid_r & out_stall);
  assign in_acc   = in_valid & ~in_stall;

  assign area_nxt   = AREA_W'(width_r) * AREA_W'(height_r);
  assign fbytes_nxt = CHROMA_W'(area_r + (area_r >> 1));

  assign actrl.step    = in_acc;
  assign actrl.restart = cfg_hit;
  assign actrl.reload  = ptr_pend_r;

  ryuv420_csc u_csc (
    .red   (in_red_in),
    .green (in_green_in),
    .blue  (in_blue_in),
    .luma  (y_val),
    .cb    (cb_val),
    .cr    (cr_val)
  );

  ryuv420_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (actrl),
    .frame_width  (width_r),
    .frame_height (height_r),
    .area         (area_r),
    .info         (ainfo)
  );

  always_comb begin
    chroma_value_nxt = '0;
    if (ainfo.chroma_valid) begin
      chroma_value_nxt = ainfo.chroma_is_u ? cb_val : cr_val;
    end
    frame_bytes_nxt = ainfo.frame_done ? fbytes_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      area_pend_r <= 1'b1;
      ptr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_r  <= clamp_dim(cfg_data, MAX_WIDTH);
          REG_FRAME_HEIGHT: height_r <= clamp_dim(cfg_data, MAX_HEIGHT);
          default: ;
        endcase
      end
      // recompute area, then load pointers from it
      area_pend_r <= cfg_hit;
      ptr_pend_r  <= area_pend_r;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (area_pend_r) begin
      area_r <= area_nxt;
    end
    if (ptr_pend_r) begin
      fbytes_r <= fbytes_nxt;
    end
    if (in_acc) begin
      luma_value_r    <= y_val;
      luma_offset_r   <= ainfo.luma_offset;
      chroma_valid_r  <= ainfo.chroma_valid;
      chroma_is_u_r   <= ainfo.chroma_is_u;
      chroma_value_r  <= chroma_value_nxt;
      chroma_offset_r <= ainfo.chroma_offset;
      frame_done_r    <= ainfo.frame_done;
      frame_bytes_r   <= frame_bytes_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_luma_value    = luma_value_r;
  assign out_luma_offset   = luma_offset_r;
  assign out_chroma_valid  = chroma_valid_r;
  assign out_chroma_is_u   = chroma_is_u_r;
  assign out_chroma_value  = chroma_value_r;
  assign out_chroma_offset = chroma_offset_r;
  assign out_frame_done    = frame_done_r;
  assign out_frame_bytes   = frame_bytes_r;

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> in_stall)
    else $error("pixel accepted right after a frame size write");

  a_pend_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (area_pend_r || ptr_pend_r) |-> !in_acc)
    else $error("pixel accepted while chroma pointers are being set up");

  a_no_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !chroma_valid_r) |->
      (chroma_offset_r == '0 && chroma_value_r == '0 && !chroma_is_u_r))
    else $error("chroma fields set on a pixel without chroma");

  a_bytes_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !frame_done_r) |-> frame_bytes_r == '0)
    else $error("frame byte count reported before the last pixel");

endmodule

### sim/yuv420_stream_checker.sv
`timescale 1ns / 1ps
// Checker for rgb_to_yuv420_stream. It tracks the frame counters and the BT.601 math
// and queues one expected YUV transaction per accepted pixel, then compares each result.
// Depends on ryuv420_pkg.
module yuv420_stream_checker
  import ryuv420_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [PIX_W-1:0]     in_blue_in,
  input  logic [PIX_W-1:0]     in_green_in,
  input  logic [PIX_W-1:0]     in_red_in,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [PIX_W-1:0]     out_luma_value,
  input  logic [LUMA_W-1:0]    out_luma_offset,
  input  logic                 out_chroma_valid,
  input  logic                 out_chroma_is_u,
  input  logic [PIX_W-1:0]     out_chroma_value,
  input  logic [CHROMA_W-1:0]  out_chroma_offset,
  input  logic                 out_frame_done,
  input  logic [CHROMA_W-1:0]  out_frame_bytes,
  output int                   fail_count,
  output int                   results_taken,
  output int                   pending_results,
  output int                   frames_closed
);

  typedef struct packed {
    logic [PIX_W-1:0]    luma_value;
    logic [LUMA_W-1:0]   luma_offset;
    logic                chroma_valid;
    logic                chroma_is_u;
    logic [PIX_W-1:0]    chroma_value;
    logic [CHROMA_W-1:0] chroma_offset;
    logic                frame_done;
    logic [CHROMA_W-1:0] frame_bytes;
  } yuv_sample_t;

  yuv_sample_t         queued_yuv[$];
  int unsigned         frame_w;
  int unsigned         frame_h;
  int unsigned         col_pos;
  int unsigned         row_pos;
  logic [LUMA_W-1:0]   luma_ptr;
  logic [CHROMA_W-1:0] u_ptr;
  logic [CHROMA_W-1:0] v_ptr;

  function automatic int unsigned fit_size(logic [DIM_W-1:0] raw, int unsigned maxv);
    if (raw == '0) return 1;
    if (raw > maxv) return maxv;
    return 32'(raw);
  endfunction

  // Back to frame start; chroma pointers follow from the current size.
  function automatic void restart_counts();
    int unsigned area;
    area = frame_w * frame_h;
    col_pos = 0;
    row_pos = 0;
    luma_ptr = '0;
    v_ptr = CHROMA_W'(area);
    u_ptr = CHROMA_W'(area + 1);
  endfunction

  function automatic yuv_sample_t convert_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                                                logic [PIX_W-1:0] r);
    yuv_sample_t s;
    int          y_sum;
    int          u_sum;
    int          v_sum;
    int unsigned area;
    s = '0;
    y_sum = C_Y_R * int'(r) + C_Y_G * int'(g) + C_Y_B * int'(b) + C_ROUND;
    u_sum = C_U_B * int'(b) - C_U_R * int'(r) - C_U_G * int'(g) + C_ROUND;
    v_sum = C_V_R * int'(r) - C_V_G * int'(g) - C_V_B * int'(b) + C_ROUND;
    s.luma_value = PIX_W'((y_sum >>> 8) + C_Y_OFS);
    s.luma_offset = luma_ptr;
    luma_ptr = luma_ptr + LUMA_W'(1);
    if (col_pos % 2 == 0) begin
      s.chroma_valid = 1'b1;
      if (row_pos % 2 == 0) begin
        s.chroma_is_u = 1'b1;
        s.chroma_value = PIX_W'((u_sum >>> 8) + C_CHR_OFS);
        s.chroma_offset = u_ptr;
        u_ptr = u_ptr + CHROMA_W'(2);
      end else begin
        s.chroma_value = PIX_W'((v_sum >>> 8) + C_CHR_OFS);
        s.chroma_offset = v_ptr;
        v_ptr = v_ptr + CHROMA_W'(2);
      end
    end
    if (col_pos + 1 >= frame_w) begin
      if (row_pos + 1 >= frame_h) begin
        area = frame_w * frame_h;
        s.frame_done = 1'b1;
        s.frame_bytes = CHROMA_W'(area + area / 2);
        restart_counts();
      end else begin
        col_pos = 0;
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    return s;
  endfunction

  function automatic int field_differs(string field, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    yuv_sample_t want;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      frame_w = RST_WIDTH;
      frame_h = RST_HEIGHT;
      restart_counts();
      queued_yuv.delete();
      fail_count <= 0;
      results_taken <= 0;
      frames_closed <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            frame_w = fit_size(cfg_data, DEF_MAX_WIDTH);
            restart_counts();
          end
          REG_FRAME_HEIGHT: begin
            frame_h = fit_size(cfg_data, DEF_MAX_HEIGHT);
            restart_counts();
          end
          default: ;
        endcase
      end
      // Retire the result before queueing this edge's pixel.
      if (out_valid && !out_stall) begin
        if (queued_yuv.size() == 0) begin
          $display("%0t: result transaction with no pixel pending", $time);
          errs++;
        end else begin
          want = queued_yuv.pop_front();
          errs += field_differs("luma_value", 32'(want.luma_value),
                                32'(out_luma_value));
          errs += field_differs("luma_offset", 32'(want.luma_offset),
                                32'(out_luma_offset));
          errs += field_differs("chroma_valid", 32'(want.chroma_valid),
                                32'(out_chroma_valid));
          errs += field_differs("chroma_is_u", 32'(want.chroma_is_u),
                                32'(out_chroma_is_u));
          errs += field_differs("chroma_value", 32'(want.chroma_value),
                                32'(out_chroma_value));
          errs += field_differs("chroma_offset", 32'(want.chroma_offset),
                                32'(out_chroma_offset));
          errs += field_differs("frame_done", 32'(want.frame_done),
                                32'(out_frame_done));
          errs += field_differs("frame_bytes", 32'(want.frame_bytes),
                                32'(out_frame_bytes));
          if (want.frame_done) frames_closed <= frames_closed + 1;
        end
        results_taken <= results_taken + 1;
      end
      if (in_valid && !in_stall) begin
        queued_yuv.push_back(convert_pixel(in_blue_in, in_green_in, in_red_in));
      end
      fail_count <= fail_count + errs;
    end
    pending_results <= queued_yuv.size();
  end

endmodule

### sim/tb_rgb_to_yuv420_stream.sv
`timescale 1ns / 1ps
// Top of the rgb_to_yuv420_stream testbench: clock, reset, pixel and register stimulus.
// Depends on ryuv420_pkg, rgb_to_yuv420_stream and yuv420_stream_checker.
module tb_rgb_to_yuv420_stream;
  import ryuv420_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B  = 2'd3;
  localparam logic [DIM_W-1:0]     DIM_ALL_ONES = '1;
  localparam int                   CYCLE_LIMIT  = 400000;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [DIM_W-1:0]     cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_blue_in  = '0;
  logic [PIX_W-1:0]     in_green_in = '0;
  logic [PIX_W-1:0]     in_red_in   = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [PIX_W-1:0]     out_luma_value;
  logic [LUMA_W-1:0]    out_luma_offset;
  logic                 out_chroma_valid;
  logic                 out_chroma_is_u;
  logic [PIX_W-1:0]     out_chroma_value;
  logic [CHROMA_W-1:0]  out_chroma_offset;
  logic                 out_frame_done;
  logic [CHROMA_W-1:0]  out_frame_bytes;

  int fail_count;
  int results_taken;
  int pending_results;
  int frames_closed;
  int pixels_sent        = 0;
  int reg_writes         = 0;
  int cycles             = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  rgb_to_yuv420_stream u_top (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_blue_in, .in_green_in, .in_red_in,
    .out_valid, .out_stall, .out_luma_value, .out_luma_offset, .out_chroma_valid,
    .out_chroma_is_u, .out_chroma_value, .out_chroma_offset, .out_frame_done,
    .out_frame_bytes
  );

  yuv420_stream_checker u_checker (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_blue_in, .in_green_in, .in_red_in,
    .out_valid, .out_stall, .out_luma_value, .out_luma_offset, .out_chroma_valid,
    .out_chroma_is_u, .out_chroma_value, .out_chroma_offset, .out_frame_done,
    .out_frame_bytes,
    .fail_count, .results_taken, .pending_results, .frames_closed
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("tb_rgb_to_yuv420_stream: FAIL");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] rand_component();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] r);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_blue_in <= b;
    in_green_in <= g;
    in_red_in <= r;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Hold off until every accepted pixel has come back out.
  task automatic drain();
    in_valid <= 1'b0;
    while (results_taken < pixels_sent) @(posedge clk);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    int unsigned      count;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    sender_idle_pct = idle_pct;
    receiver_stall_pct <= stall_pct;
    repeat (6) begin
      case ($urandom_range(0, 9))
        0: w = '0;
        1: w = DIM_W'($urandom_range(DEF_MAX_WIDTH - 4, (1 << DIM_W) - 1));
        default: w = DIM_W'($urandom_range(1, 10));
      endcase
      case ($urandom_range(0, 9))
        0: h = '0;
        1: h = DIM_W'($urandom_range(DEF_MAX_HEIGHT - 4, (1 << DIM_W) - 1));
        default: h = DIM_W'($urandom_range(1, 6));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, DIM_W'($urandom));
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_WIDTH, w);
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_HEIGHT, h);
      cfg_valid <= 1'b0;
      count = $urandom_range(40, 85);
      repeat (count) send_pixel(rand_component(), rand_component(), rand_component());
      drain();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset size 640x480: pointers start from the reset area.
    send_pixel('0, '0, '0);
    send_pixel('1, '1, '1);
    send_pixel('0, '0, '1);
    drain();
    // Writes past the register list must not restart the frame.
    write_reg(REG_SPARE_A, DIM_ALL_ONES);
    write_reg(REG_SPARE_B, '0);
    cfg_valid <= 1'b0;
    send_pixel('0, '1, '0);
    drain();

    // Odd width, two rows: U row then V row, then wrap to frame start.
    set_frame(DIM_W'(3), DIM_W'(2));
    send_pixel('1, '0, '0);
    send_pixel('0, '1, '0);
    send_pixel('0, '0, '1);
    send_pixel('1, '1, '0);
    send_pixel('0, '1, '1);
    send_pixel('1, '0, '1);
    send_pixel(8'h80, 8'h80, 8'h80);
    drain();

    // Zero sizes act as one: every pixel closes a frame.
    set_frame('0, '0);
    send_pixel('1, '1, '1);
    send_pixel('0, '0, '0);
    send_pixel(8'h12, 8'hA5, 8'h5A);
    drain();

    // Oversized values clamp to the maximum frame.
    set_frame(DIM_ALL_ONES, DIM_W'(DEF_MAX_HEIGHT + 1));
    send_pixel('1, '0, '0);
    send_pixel('0, '0, '1);
    send_pixel('1, '1, '1);
    drain();

    // A width write alone restarts the frame mid-row.
    write_reg(REG_FRAME_WIDTH, DIM_W'(2));
    cfg_valid <= 1'b0;
    send_pixel('0, '1, '1);
    send_pixel('1, '0, '1);
    send_pixel('1, '1, '0);
    drain();

    run_random_phase(0, 0);
    run_random_phase(61, 0);
    run_random_phase(0, 61);
    run_random_phase(29, 29);
    drain();
    repeat (4) @(posedge clk);

    if (pending_results != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results);
    end
    $display("Covered %0d pixels, %0d completed frames and %0d register writes,",
             pixels_sent, frames_closed, reg_writes);
    $display("with sender gaps and receiver stalls applied alone and together.");
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb_rgb_to_yuv420_stream: PASS");
    end else begin
      $display("tb_rgb_to_yuv420_stream: FAIL");
    end
    $finish;
  end

endmodule

### files.f
design/ryuv420_pkg.sv
design/ryuv420_csc.sv
design/ryuv420_addr.sv
design/rgb_to_yuv420_stream.sv
sim/yuv420_stream_checker.sv
sim/tb_rgb_to_yuv420_stream.sv
